>>> rtl/mgt_pkg.sv
// Shared constants for the masked grid triangulator.
// No dependencies; imported by masked_grid_triangulator_core.
package mgt_pkg;

    localparam int FIELD_BITS     = 20;   // width of every index field on the result port
    localparam int CFG_DATA_BITS  = 11;   // width of a configuration value
    localparam int CFG_INDEX_BITS = 2;    // width of a configuration register index
    localparam int ROW_BITS       = 10;   // row counter width
    localparam int MAX_HEIGHT     = 1024; // largest usable grid height

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

endpackage

>>> rtl/masked_grid_triangulator_core.sv
// Masked grid triangulator: dense vertex numbering and quad triangulation of a
// row-major validity mask. Depends on mgt_pkg.
// Input channel (s_valid/s_ready/s_pixel_valid): one validity bit per grid
//   pixel in row-major order, one request per cycle while s_ready is high.
// Result channel (m_valid/m_ready/m_*): exactly one result per pixel with its
//   vertex index when valid, up to two triangles when it closes a quad, a
//   frame_last marker and a flag once the vertex counter saturates at 2^INDEX_BITS.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): grid width
//   and height, clamped on write; a write to either restarts the frame.
//   Write only while no pixel is in flight. cfg_ready is always 1.
// Timing: one pixel per cycle while the result register is not stalled. A pixel
//   accepted sits in the input stage, where the line store read for its column
//   lands; once it advances, the result register loads and m_valid rises. The
//   registered line store read, issued at acceptance, sets this two-register depth.
// Reset and stall: synchronous active-low reset clears the counters, the
//   neighbor registers and both stage valids; the line store needs no clearing
//   since row 0 of every frame writes it before it is read. When m_ready is low
//   the result register holds, the input stage fills, and s_ready drops only
//   while both stages are occupied.
module masked_grid_triangulator_core
    import mgt_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int INDEX_BITS = 20
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_pixel_valid,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_vertex_valid,
    output logic [FIELD_BITS-1:0]     m_vertex_index,
    output logic                      m_tri0_valid,
    output logic [FIELD_BITS-1:0]     m_tri0_a,
    output logic [FIELD_BITS-1:0]     m_tri0_b,
    output logic [FIELD_BITS-1:0]     m_tri0_c,
    output logic                      m_tri1_valid,
    output logic [FIELD_BITS-1:0]     m_tri1_a,
    output logic [FIELD_BITS-1:0]     m_tri1_b,
    output logic [FIELD_BITS-1:0]     m_tri1_c,
    output logic                      m_frame_last,
    output logic                      m_index_overflow
);

    localparam int COL_BITS = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [COL_BITS-1:0] WIDTH_LAST_RST =
        COL_BITS'(((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024) - 1);
    localparam logic [ROW_BITS-1:0] HEIGHT_LAST_RST = ROW_BITS'(MAX_HEIGHT - 1);

    typedef struct packed {
        logic                  valid;
        logic [INDEX_BITS-1:0] index;
    } corner_t;

    // Clamp a written width to [2, MAX_WIDTH] and keep it as last column.
    function automatic logic [COL_BITS-1:0] width_last(input logic [CFG_DATA_BITS-1:0] v);
        logic [COL_BITS-1:0] r;
        if (v < CFG_DATA_BITS'(2)) begin
            r = COL_BITS'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            r = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            r = COL_BITS'(v - 1'b1);
        end
        return r;
    endfunction

    // Clamp a written height to [2, MAX_HEIGHT] and keep it as last row.
    function automatic logic [ROW_BITS-1:0] height_last(input logic [CFG_DATA_BITS-1:0] v);
        logic [ROW_BITS-1:0] r;
        if (v < CFG_DATA_BITS'(2)) begin
            r = ROW_BITS'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            r = ROW_BITS'(MAX_HEIGHT - 1);
        end else begin
            r = ROW_BITS'(v - 1'b1);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [COL_BITS-1:0] width_last_reg;
    logic [ROW_BITS-1:0] height_last_reg;
    logic                cfg_write;
    logic                cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    // Writes outside the register list are dropped and do not restart the frame.
    assign cfg_hit   = cfg_write &&
                       ((cfg_index == REG_GRID_WIDTH) || (cfg_index == REG_GRID_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_last_reg  <= WIDTH_LAST_RST;
            height_last_reg <= HEIGHT_LAST_RST;
        end else if (cfg_write) begin
            if (cfg_index == REG_GRID_WIDTH) begin
                width_last_reg <= width_last(cfg_data);
            end
            if (cfg_index == REG_GRID_HEIGHT) begin
                height_last_reg <= height_last(cfg_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake between acceptance, input stage and result register
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic s_accept;
    logic s1_advance;

    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Acceptance side: grid position and line store read
    // ------------------------------------------------------------------
    logic [COL_BITS-1:0] col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic                row_end;
    logic                frame_end;

    assign row_end   = (col_reg == width_last_reg);
    assign frame_end = row_end && (row_reg == height_last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            if (row_end) begin
                col_reg <= '0;
                row_reg <= frame_end ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Input stage: the pixel plus everything known about its position.
    logic                s1_pixel_reg;
    logic [COL_BITS-1:0] s1_col_reg;
    logic                s1_quad_reg;
    logic                s1_row_end_reg;
    logic                s1_frame_end_reg;
    corner_t             s1_above_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pixel_reg     <= s_pixel_valid;
            s1_col_reg       <= col_reg;
            s1_quad_reg      <= (row_reg != '0) && (col_reg != '0);
            s1_row_end_reg   <= row_end;
            s1_frame_end_reg <= frame_end;
        end
    end

    // Line store: one entry per column of the previous row. The same column
    // comes back at least two requests later, so its write always lands
    // before the read that needs it.
    corner_t line_mem [MAX_WIDTH];
    corner_t cur;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_above_reg <= line_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            line_mem[s1_col_reg] <= cur;
        end
    end

    // ------------------------------------------------------------------
    // Process stage: vertex numbering and quad triangulation
    // ------------------------------------------------------------------
    logic [INDEX_BITS:0] vcnt_reg;
    logic [INDEX_BITS:0] vcnt_next;
    corner_t             left_reg;
    corner_t             above_left_reg;
    logic                vcnt_full;

    assign vcnt_full = vcnt_reg[INDEX_BITS];

    always_comb begin
        cur.valid = s1_pixel_reg && !vcnt_full;
        cur.index = cur.valid ? vcnt_reg[INDEX_BITS-1:0] : '0;
        vcnt_next = cur.valid ? vcnt_reg + 1'b1 : vcnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            vcnt_reg       <= '0;
            left_reg       <= '0;
            above_left_reg <= '0;
        end else if (s1_advance) begin
            vcnt_reg <= s1_frame_end_reg ? '0 : vcnt_next;
            // Drop the neighbors at a row end; the next pixel starts a row.
            if (s1_row_end_reg) begin
                left_reg       <= '0;
                above_left_reg <= '0;
            end else begin
                left_reg       <= cur;
                above_left_reg <= s1_above_reg;
            end
        end
    end

    // Quad corners: 0 above-left, 1 above, 2 current, 3 left.
    logic [3:0]            qv;
    logic [FIELD_BITS-1:0] qi [4];
    logic                  t012, t123, t230, t301;
    logic                  tri0_v, tri1_v;
    logic [FIELD_BITS-1:0] tri0_a, tri0_b, tri0_c, tri1_a, tri1_b, tri1_c;

    always_comb begin
        qv    = {left_reg.valid, cur.valid, s1_above_reg.valid, above_left_reg.valid};
        qi[0] = FIELD_BITS'(above_left_reg.index);
        qi[1] = FIELD_BITS'(s1_above_reg.index);
        qi[2] = FIELD_BITS'(cur.index);
        qi[3] = FIELD_BITS'(left_reg.index);

        t012 = qv[0] && qv[1] && qv[2];
        t123 = qv[1] && qv[2] && qv[3];
        t230 = qv[2] && qv[3] && qv[0];
        t301 = qv[3] && qv[0] && qv[1];

        tri0_v = 1'b0; tri0_a = '0; tri0_b = '0; tri0_c = '0;
        tri1_v = 1'b0; tri1_a = '0; tri1_b = '0; tri1_c = '0;

        // A matching triple skips the next one in the order.
        if (s1_quad_reg) begin
            if (t012) begin
                tri0_v = 1'b1; tri0_a = qi[0]; tri0_b = qi[1]; tri0_c = qi[2];
                if (t230) begin
                    tri1_v = 1'b1; tri1_a = qi[2]; tri1_b = qi[3]; tri1_c = qi[0];
                end
            end else if (t123) begin
                tri0_v = 1'b1; tri0_a = qi[1]; tri0_b = qi[2]; tri0_c = qi[3];
                if (t301) begin
                    tri1_v = 1'b1; tri1_a = qi[3]; tri1_b = qi[0]; tri1_c = qi[1];
                end
            end else if (t230) begin
                tri0_v = 1'b1; tri0_a = qi[2]; tri0_b = qi[3]; tri0_c = qi[0];
            end else if (t301) begin
                tri0_v = 1'b1; tri0_a = qi[3]; tri0_b = qi[0]; tri0_c = qi[1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_vertex_valid   <= cur.valid;
            m_vertex_index   <= FIELD_BITS'(cur.index);
            m_tri0_valid     <= tri0_v;
            m_tri0_a         <= tri0_a;
            m_tri0_b         <= tri0_b;
            m_tri0_c         <= tri0_c;
            m_tri1_valid     <= tri1_v;
            m_tri1_a         <= tri1_a;
            m_tri1_b         <= tri1_b;
            m_tri1_c         <= tri1_c;
            m_frame_last     <= s1_frame_end_reg;
            m_index_overflow <= vcnt_next[INDEX_BITS];
        end
    end

    assign m_valid = m_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_tri_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tri1_valid |-> m_tri0_valid)
        else $error("second triangle without first triangle");

    a_vcnt_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        vcnt_reg[INDEX_BITS] |-> (vcnt_reg[INDEX_BITS-1:0] == '0))
        else $error("vertex counter passed saturation");

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_advance |=>
            s1_valid_reg && $stable(s1_col_reg) && $stable(s1_pixel_reg))
        else $error("input stage lost a stalled request");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for masked_grid_triangulator_core: vertex numbering,
// quad triangulation, register clamping and frame wrap under random flow control.
// Depends on mgt_pkg and the core RTL only.
module testbench;
    import mgt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_MAX_W       = 1024;
    localparam int VTX_INDEX_BITS   = 20;
    localparam int INDEX_FULL       = 1 << VTX_INDEX_BITS;
    localparam int HOLD_CYCLES      = 60;   // long receiver hold-off
    localparam int HOLD_AFTER       = 400;  // results seen before the hold-off starts
    localparam int RANDOM_PIXELS    = 1550;
    localparam int FULL_RATE_PIXELS = 250;
    localparam int FULL_RATE_WIDTH  = 20;

    // Indexes the core does not decode; a write there must not restart the frame.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

    // 2x2 frames, corners packed as {above-left, above, left, current}:
    // full quad, current missing, above-left missing, above missing,
    // left missing, empty quad.
    localparam logic [3:0] QUAD_CASES [6] = '{4'b1111, 4'b1110, 4'b0111,
                                              4'b1011, 4'b1101, 4'b0000};

    // One result per pixel: its vertex and the triangles of the quad it closes.
    typedef struct packed {
        logic                  vertex_valid;
        logic [FIELD_BITS-1:0] vertex_index;
        logic                  tri0_valid;
        logic [FIELD_BITS-1:0] tri0_a;
        logic [FIELD_BITS-1:0] tri0_b;
        logic [FIELD_BITS-1:0] tri0_c;
        logic                  tri1_valid;
        logic [FIELD_BITS-1:0] tri1_a;
        logic [FIELD_BITS-1:0] tri1_b;
        logic [FIELD_BITS-1:0] tri1_c;
        logic                  frame_last;
        logic                  index_overflow;
    } pixel_mesh_t;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data      = '0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic                      s_pixel_valid = 1'b0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic                      m_vertex_valid;
    logic [FIELD_BITS-1:0]     m_vertex_index;
    logic                      m_tri0_valid;
    logic [FIELD_BITS-1:0]     m_tri0_a;
    logic [FIELD_BITS-1:0]     m_tri0_b;
    logic [FIELD_BITS-1:0]     m_tri0_c;
    logic                      m_tri1_valid;
    logic [FIELD_BITS-1:0]     m_tri1_a;
    logic [FIELD_BITS-1:0]     m_tri1_b;
    logic [FIELD_BITS-1:0]     m_tri1_c;
    logic                      m_frame_last;
    logic                      m_index_overflow;

    // Stimulus and scoreboard bookkeeping.
    logic        pixel_feed[$];     // validity bits waiting to be requested
    pixel_mesh_t meshes_due[$];     // predicted results, oldest first
    logic        pixel_taken = 1'b0;
    int          idle_pct    = 19;
    int          meshes_seen = 0;
    int          mismatches  = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;

    // Predictor state: the shadow configuration and the core's counters.
    int width_cfg  = GRID_MAX_W;
    int height_cfg = MAX_HEIGHT;
    int col_pos;
    int row_pos;
    int next_vertex;
    bit above_valid [GRID_MAX_W];
    int above_index [GRID_MAX_W];
    bit left_valid;
    int left_index;
    bit diag_valid;
    int diag_index;

    masked_grid_triangulator_core #(
        .MAX_WIDTH (GRID_MAX_W),
        .INDEX_BITS(VTX_INDEX_BITS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_valid   (s_pixel_valid),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_vertex_valid  (m_vertex_valid),
        .m_vertex_index  (m_vertex_index),
        .m_tri0_valid    (m_tri0_valid),
        .m_tri0_a        (m_tri0_a),
        .m_tri0_b        (m_tri0_b),
        .m_tri0_c        (m_tri0_c),
        .m_tri1_valid    (m_tri1_valid),
        .m_tri1_a        (m_tri1_a),
        .m_tri1_b        (m_tri1_b),
        .m_tri1_c        (m_tri1_c),
        .m_frame_last    (m_frame_last),
        .m_index_overflow(m_index_overflow)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int grid_clamp(input int value, input int hi);
        return (value < 2) ? 2 : (value > hi) ? hi : value;
    endfunction

    // Return to the first pixel of a frame. The line store keeps its contents:
    // row 0 of the new frame overwrites it before anything reads it.
    function automatic void restart_frame();
        col_pos     = 0;
        row_pos     = 0;
        next_vertex = 0;
        left_valid  = 1'b0;
        left_index  = 0;
        diag_valid  = 1'b0;
        diag_index  = 0;
    endfunction

    function automatic void apply_grid_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                           input int value);
        if (idx == REG_GRID_WIDTH) begin
            width_cfg = value;
        end else if (idx == REG_GRID_HEIGHT) begin
            height_cfg = value;
        end else begin
            return;
        end
        restart_frame();
    endfunction

    // Number one pixel, close its quad if it is a lower-right corner, and
    // advance the raster position.
    function automatic pixel_mesh_t number_and_triangulate(input logic pix);
        pixel_mesh_t m;
        int          w;
        int          h;
        int          col;
        int          i;
        int          tris;
        bit          cur_valid;
        int          cur_index;
        bit          up_valid;
        int          up_index;
        bit          cv [4];
        int          ci [4];

        m         = '0;
        w         = grid_clamp(width_cfg, GRID_MAX_W);
        h         = grid_clamp(height_cfg, MAX_HEIGHT);
        col       = (col_pos >= w) ? w - 1 : col_pos;
        cur_valid = 1'b0;
        cur_index = 0;
        tris      = 0;

        // A valid pixel past the last free index counts as no-data.
        if (pix && next_vertex < INDEX_FULL) begin
            cur_valid = 1'b1;
            cur_index = next_vertex;
            next_vertex++;
        end
        m.vertex_valid = cur_valid;
        m.vertex_index = cur_index[FIELD_BITS-1:0];

        up_valid = above_valid[col];
        up_index = above_index[col];

        // Corners: above-left, above, current, left. Walk the triples in
        // order; an emitted triple skips the next start corner.
        if (row_pos >= 1 && col >= 1) begin
            cv = '{diag_valid, up_valid, cur_valid, left_valid};
            ci = '{diag_index, up_index, cur_index, left_index};
            i  = 0;
            while (i < 4 && tris < 2) begin
                if (cv[i] && cv[(i + 1) % 4] && cv[(i + 2) % 4]) begin
                    if (tris == 0) begin
                        m.tri0_valid = 1'b1;
                        m.tri0_a     = ci[i][FIELD_BITS-1:0];
                        m.tri0_b     = ci[(i + 1) % 4][FIELD_BITS-1:0];
                        m.tri0_c     = ci[(i + 2) % 4][FIELD_BITS-1:0];
                    end else begin
                        m.tri1_valid = 1'b1;
                        m.tri1_a     = ci[i][FIELD_BITS-1:0];
                        m.tri1_b     = ci[(i + 1) % 4][FIELD_BITS-1:0];
                        m.tri1_c     = ci[(i + 2) % 4][FIELD_BITS-1:0];
                    end
                    tris++;
                    i += 2;
                end else begin
                    i++;
                end
            end
        end

        above_valid[col] = cur_valid;
        above_index[col] = cur_index;
        diag_valid       = up_valid;
        diag_index       = up_index;
        left_valid       = cur_valid;
        left_index       = cur_index;

        m.index_overflow = (next_vertex >= INDEX_FULL);

        // End of row: drop the left neighbors; end of frame: start over.
        if (col + 1 >= w) begin
            col_pos    = 0;
            left_valid = 1'b0;
            left_index = 0;
            diag_valid = 1'b0;
            diag_index = 0;
            if (row_pos + 1 >= h) begin
                m.frame_last = 1'b1;
                restart_frame();
            end else begin
                row_pos++;
            end
        end else begin
            col_pos = col + 1;
        end
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Pixel request driver: change only at the falling edge, hold the
    // request until the rising edge that takes it.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || pixel_taken)) begin
            if (pixel_feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_valid       <= 1'b1;
                s_pixel_valid <= pixel_feed.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Pixel monitor: predict the result of each accepted request.
    always @(posedge aclk) begin
        pixel_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            meshes_due.insert(meshes_due.size(), number_and_triangulate(s_pixel_valid));
        end
    end

    // Result receiver: random back-pressure plus one long hold-off, started
    // while pixels are still queued so the core fills and drops s_ready.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && meshes_seen >= HOLD_AFTER && pixel_feed.size() >= 8) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    function automatic void check_field(input string name, input logic [FIELD_BITS-1:0] want,
                                        input logic [FIELD_BITS-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d: %s expected %0d, got %0d", meshes_seen, name, want, got);
            end
        end
    endfunction

    // Result monitor: compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin : result_monitor
        pixel_mesh_t want;
        if (aresetn && m_valid && m_ready) begin
            if (meshes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: no prediction pending", meshes_seen);
                end
            end else begin
                want = meshes_due.pop_front();
                check_field("vertex_valid", FIELD_BITS'(want.vertex_valid),
                            FIELD_BITS'(m_vertex_valid));
                check_field("vertex_index", want.vertex_index, m_vertex_index);
                check_field("tri0_valid", FIELD_BITS'(want.tri0_valid),
                            FIELD_BITS'(m_tri0_valid));
                check_field("tri0_a", want.tri0_a, m_tri0_a);
                check_field("tri0_b", want.tri0_b, m_tri0_b);
                check_field("tri0_c", want.tri0_c, m_tri0_c);
                check_field("tri1_valid", FIELD_BITS'(want.tri1_valid),
                            FIELD_BITS'(m_tri1_valid));
                check_field("tri1_a", want.tri1_a, m_tri1_a);
                check_field("tri1_b", want.tri1_b, m_tri1_b);
                check_field("tri1_c", want.tri1_c, m_tri1_c);
                check_field("frame_last", FIELD_BITS'(want.frame_last),
                            FIELD_BITS'(m_frame_last));
                check_field("index_overflow", FIELD_BITS'(want.index_overflow),
                            FIELD_BITS'(m_index_overflow));
            end
            meshes_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------

    // Write one register; the predictor follows at the accepting edge.
    task automatic write_grid_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_grid_reg(idx, value & 32'h7FF);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued pixel is taken and every result is back, then
    // give the two-stage pipeline a few spare cycles.
    task automatic wait_idle();
        while (pixel_feed.size() != 0 || s_valid || meshes_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Mostly small grids; now and then a value the core must clamp.
    function automatic int pick_width();
        case ($urandom_range(15))
            0:       return 0;
            1:       return 1;
            2:       return 2047;
            3:       return 1025;
            4:       return GRID_MAX_W;
            5:       return $urandom_range(17, 40);
            default: return $urandom_range(2, 16);
        endcase
    endfunction

    function automatic int pick_height();
        case ($urandom_range(15))
            0:       return 0;
            1:       return 1;
            2:       return 2047;
            3:       return 1025;
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int w;
        int h;
        int n;
        int pct;
        int k;
        int b;
        int random_px;

        restart_frame();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: out-of-range values clamp to a 2x2 grid, then one frame
        // per corner pattern so every triple order is hit.
        write_grid_reg(REG_GRID_WIDTH, 0);
        write_grid_reg(REG_GRID_HEIGHT, 1);
        for (k = 0; k < 6; k++) begin
            for (b = 3; b >= 0; b--) begin
                pixel_feed.insert(pixel_feed.size(), QUAD_CASES[k][b]);
            end
        end
        wait_idle();

        // Random phases: new geometry (or a write the core ignores, so the
        // frame carries on), then whole frames with an optional partial one, or on
        // large grids only part of a frame, that the next register write cuts short.
        random_px = 0;
        while (random_px < RANDOM_PIXELS) begin
            case ($urandom_range(3))
                0: write_grid_reg(REG_GRID_WIDTH, pick_width());
                1: write_grid_reg(REG_GRID_HEIGHT, pick_height());
                2: begin
                    write_grid_reg(REG_GRID_HEIGHT, pick_height());
                    write_grid_reg(REG_GRID_WIDTH, pick_width());
                end
                default: write_grid_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                                        $urandom_range(2047));
            endcase

            w = grid_clamp(width_cfg, GRID_MAX_W);
            h = grid_clamp(height_cfg, MAX_HEIGHT);
            if (w > 64) begin
                n = $urandom_range(3, 40);
            end else if (h > 16) begin
                n = w * $urandom_range(2, 6) + $urandom_range(0, w - 1);
            end else begin
                n = w * h * $urandom_range(1, 3);
                if ($urandom_range(2) == 0) begin
                    n += $urandom_range(1, w * h - 1);
                end
            end

            case ($urandom_range(3))
                0:       pct = 97;
                1:       pct = 80;
                2:       pct = 50;
                default: pct = 15;
            endcase
            for (k = 0; k < n; k++) begin
                pixel_feed.insert(pixel_feed.size(), $urandom_range(99) < pct);
            end
            wait_idle();
            random_px += n;
        end

        // Full rate with no idling on either side: a narrow grid at the
        // largest height, every pixel valid, so every quad yields two triangles.
        write_grid_reg(REG_GRID_WIDTH, FULL_RATE_WIDTH);
        write_grid_reg(REG_GRID_HEIGHT, MAX_HEIGHT);
        idle_pct = 0;
        for (k = 0; k < FULL_RATE_PIXELS; k++) begin
            pixel_feed.insert(pixel_feed.size(), 1'b1);
        end
        wait_idle();
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && meshes_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: the whole run needs well under 0.2 ms even with every stall.
    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> masked_grid_triangulator_core.f
rtl/mgt_pkg.sv
rtl/masked_grid_triangulator_core.sv
tb/testbench.sv
